@@ rtl/linear_interp_resampler_with_gain_macros.svh @@
// Assertion macros used by the resampler's port-level checks.
`ifndef LINEAR_INTERP_RESAMPLER_WITH_GAIN_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_WITH_GAIN_MACROS_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define LIRG_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after reset is sampled low.
`define LIRG_ASSERT_RST(lbl, clk_s, rst_s, cons, msg) \
  lbl: assert property (@(posedge clk_s) !(rst_s) |=> (cons)) else $error(msg);

`endif

@@ rtl/lirg_pkg.sv @@
// Shared constants and types of the linear interpolation resampler.
package lirg_pkg;

  // Default parameter values.
  localparam int unsigned STEP_BITS_DEF = 16;
  localparam int unsigned MAX_OUT_DEF   = 64;

  // Field and register widths.
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned VALUE_W   = 25;
  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned OFFSET_W  = 17;
  localparam int unsigned ZERO_W    = 16;
  localparam int unsigned BITS_W    = 5;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned NUM_W     = VALUE_W + 1 + FRAC_W;

  // Reset values and limits.
  localparam logic [GAIN_W-1:0]  GAIN_RST = GAIN_W'(65536);
  localparam logic [BITS_W-1:0]  BITS_RST = BITS_W'(12);
  localparam logic [BITS_W-1:0]  BITS_MIN = BITS_W'(8);
  localparam logic [BITS_W-1:0]  BITS_MAX = BITS_W'(16);
  localparam logic [VALUE_W-1:0] VAL_MAX  = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VAL_MIN  = {1'b1, {(VALUE_W-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_STEP  = 3'd0,
    CFG_OUTPUT_STEP = 3'd1,
    CFG_GAIN        = 3'd2,
    CFG_OFFSET      = 3'd3,
    CFG_OUT_ZERO    = 3'd4,
    CFG_OUT_BITS    = 3'd5
  } cfg_idx_t;

  // Status of the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/lirg_div.sv @@
// Shared restoring divider: one quotient bit per cycle.
module lirg_div #(
  parameter int unsigned DVD_W = 42,
  parameter int unsigned DVS_W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DVD_W-1:0]    dividend,
  input  logic [DVS_W-1:0]    divisor,
  output lirg_pkg::div_stat_t stat,
  output logic [DVD_W-1:0]    quotient,
  output logic [DVS_W-1:0]    remainder
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             fits;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    fits    = (rem_sh >= {1'b0, dvs_r});
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient shifts in from the bottom as the dividend shifts out the top.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], fits};
      rem_r <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign stat      = '{busy: busy_r, done: done_r};
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ rtl/linear_interp_resampler_with_gain.sv @@
// Rational-rate linear interpolation resampler with gain and offset, one channel.
// Equal steps: a beat passes the gain and scale states to the emit state; no new beat is taken
// until the result is sent. Otherwise each result runs the shared bit-serial divider once for
// the phase and once for the quotient; a beat also passes the wrap and advance states, and the
// divider runs once more for the skip count when output instants beyond the cap are skipped.
// Synchronous active-low reset clears the times, the previous value, the primed flag, the count, out_valid and config.
module linear_interp_resampler_with_gain #(
  parameter int unsigned STEP_BITS      = lirg_pkg::STEP_BITS_DEF,
  parameter int unsigned MAX_OUT_PER_IN = lirg_pkg::MAX_OUT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [lirg_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lirg_pkg::VALUE_W-1:0]  out_value,
  output logic                                out_out_of_range,
  output logic                                out_last,
  input  logic                                cfg_wr_en,
  input  logic [lirg_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [lirg_pkg::CFG_W-1:0]           cfg_wdata
);

  import lirg_pkg::*;

  localparam int unsigned TW    = 2 * STEP_BITS + 2;
  localparam int unsigned DIV_W = (VALUE_W + 1 + STEP_BITS > TW) ?
                                  (VALUE_W + 1 + STEP_BITS) : TW;
  localparam int unsigned ACC_W = DIV_W + 1;
  localparam int unsigned MA_W  = (VALUE_W + 1 > STEP_BITS + 2) ?
                                  (VALUE_W + 1) : (STEP_BITS + 2);
  localparam int unsigned MB_W  = (GAIN_W > STEP_BITS) ? GAIN_W : STEP_BITS;
  localparam int unsigned P_W   = MA_W + MB_W + 1;
  localparam int unsigned CNT_W = $clog2(MAX_OUT_PER_IN + 1);

  typedef enum logic [16:0] {
    ST_IDLE    = 17'h00001,
    ST_GAIN    = 17'h00002,
    ST_SCALE   = 17'h00004,
    ST_NM      = 17'h00008,
    ST_CHECK   = 17'h00010,
    ST_MOD     = 17'h00020,
    ST_MP      = 17'h00040,
    ST_MK      = 17'h00080,
    ST_ADD     = 17'h00100,
    ST_ABS     = 17'h00200,
    ST_QUOT    = 17'h00400,
    ST_EMIT    = 17'h00800,
    ST_SKIP    = 17'h01000,
    ST_SKIPMUL = 17'h02000,
    ST_SKIPADD = 17'h04000,
    ST_WRAP    = 17'h08000,
    ST_ADV     = 17'h10000
  } state_t;

  // Configuration registers.
  logic [STEP_BITS-1:0]       in_step_r;
  logic [STEP_BITS-1:0]       out_step_r;
  logic [GAIN_W-1:0]          gain_r;
  logic signed [OFFSET_W-1:0] offset_r;
  logic signed [ZERO_W-1:0]   zero_r;
  logic [BITS_W-1:0]          bits_r;

  // Sequencer and datapath state.
  state_t                     state_r;
  state_t                     state_nxt;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [P_W-1:0]      mul_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [VALUE_W-1:0]  v_r;
  logic signed [VALUE_W-1:0]  prev_r;
  logic signed [VALUE_W-1:0]  q_r;
  logic [TW-1:0]              it_r;
  logic [TW-1:0]              ot_r;
  logic [TW-1:0]              nm_r;
  logic [STEP_BITS-1:0]       k_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       primed_r;
  logic                       eq_r;
  logic                       neg_r;

  // Output register.
  logic                       out_valid_r;
  logic signed [VALUE_W-1:0]  out_value_r;
  logic                       out_oor_r;
  logic                       out_last_r;

  // Combinational helpers.
  logic [STEP_BITS-1:0]       n_eff;
  logic [STEP_BITS-1:0]       m_eff;
  logic                       steps_eq;
  logic                       due;
  logic                       cap;
  logic                       more;
  logic                       out_free;
  logic [TW-1:0]              ot_plus;
  logic signed [MA_W-1:0]     mul_a;
  logic [MB_W-1:0]            mul_b;
  logic signed [NUM_W-1:0]    num;
  logic signed [NUM_W-1:0]    num_adj;
  logic signed [NUM_W-1:0]    offset_ext;
  logic [VALUE_W:0]           sc;
  logic signed [VALUE_W-1:0]  v_new;
  logic signed [VALUE_W:0]    diff;
  logic [STEP_BITS:0]         skip_cnt;
  logic signed [ACC_W-1:0]    acc_neg;
  logic [VALUE_W:0]           qmag;
  logic [VALUE_W:0]           q_s;
  logic [BITS_W-1:0]          bits_c;
  logic [ZERO_W:0]            half;
  logic signed [VALUE_W-1:0]  zero_x;
  logic signed [VALUE_W-1:0]  half_x;
  logic signed [VALUE_W-1:0]  hi_x;
  logic signed [VALUE_W-1:0]  lo_x;

  // Divider interface.
  logic                       div_start;
  logic [DIV_W-1:0]           div_dvd;
  logic [STEP_BITS-1:0]       div_dvs;
  div_stat_t                  div_stat;
  logic [DIV_W-1:0]           div_quo;
  logic [STEP_BITS-1:0]       div_rem;

  // A step register holding zero acts as one.
  always_comb begin
    n_eff    = (in_step_r == '0) ? STEP_BITS'(1) : in_step_r;
    m_eff    = (out_step_r == '0) ? STEP_BITS'(1) : out_step_r;
    steps_eq = (n_eff == m_eff);
    due      = (ot_r <= it_r);
    cap      = (cnt_r == CNT_W'(MAX_OUT_PER_IN));
    ot_plus  = ot_r + TW'(m_eff);
    more     = (ot_plus <= it_r) && (cnt_r < CNT_W'(MAX_OUT_PER_IN - 1));
    out_free = !out_valid_r || !out_stall;
  end

  // Gain stage: add the offset, drop the fraction bits, rounding toward zero, then saturate.
  always_comb begin
    offset_ext = {{(NUM_W-OFFSET_W-FRAC_W){offset_r[OFFSET_W-1]}}, offset_r,
                  {FRAC_W{1'b0}}};
    num        = $signed(mul_r[NUM_W-1:0]) + offset_ext;
    num_adj    = num + (num[NUM_W-1] ? NUM_W'({FRAC_W{1'b1}}) : NUM_W'(0));
    sc         = num_adj[NUM_W-1:FRAC_W];
    if (sc[VALUE_W] != sc[VALUE_W-1]) begin
      v_new = sc[VALUE_W] ? VAL_MIN : VAL_MAX;
    end else begin
      v_new = sc[VALUE_W-1:0];
    end
  end

  // Interpolation terms and quotient sign handling.
  always_comb begin
    diff     = {v_r[VALUE_W-1], v_r} - {prev_r[VALUE_W-1], prev_r};
    skip_cnt = {1'b0, div_quo[STEP_BITS-1:0]} + (STEP_BITS+1)'(1);
    acc_neg  = -acc_r;
    qmag     = div_quo[VALUE_W:0];
    q_s      = neg_r ? -qmag : qmag;
  end

  // Output ADC window, resolution clamped into eight to sixteen bits.
  always_comb begin
    if (bits_r < BITS_MIN) begin
      bits_c = BITS_MIN;
    end else if (bits_r > BITS_MAX) begin
      bits_c = BITS_MAX;
    end else begin
      bits_c = bits_r;
    end
    half   = (ZERO_W+1)'(1) << (bits_c - BITS_W'(1));
    zero_x = VALUE_W'(zero_r);
    half_x = VALUE_W'(half);
    hi_x   = zero_x + (half_x - 25'sd1);
    lo_x   = zero_x - half_x;
  end

  // Shared multiplier operand selection.
  always_comb begin
    unique case (state_r)
      ST_GAIN: begin
        mul_a = MA_W'(sample_r);
        mul_b = MB_W'(gain_r);
      end
      ST_SCALE: begin
        mul_a = MA_W'(n_eff);
        mul_b = MB_W'(m_eff);
      end
      ST_MP: begin
        mul_a = MA_W'(prev_r);
        mul_b = MB_W'(n_eff);
      end
      ST_MK: begin
        mul_a = MA_W'(diff);
        mul_b = MB_W'(k_r);
      end
      ST_SKIPMUL: begin
        mul_a = MA_W'(skip_cnt);
        mul_b = MB_W'(m_eff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider launch: phase of the output instant, skip count, or interpolation quotient.
  always_comb begin
    div_start = ((state_r == ST_CHECK) && due) || (state_r == ST_ABS);
    div_dvs   = n_eff;
    if (state_r == ST_ABS) begin
      div_dvd = acc_r[ACC_W-1] ? acc_neg[DIV_W-1:0] : acc_r[DIV_W-1:0];
    end else if (cap) begin
      div_dvd = DIV_W'(it_r - ot_r);
      div_dvs = m_eff;
    end else begin
      div_dvd = DIV_W'(ot_r);
    end
  end

  lirg_div #(
    .DVD_W (DIV_W),
    .DVS_W (STEP_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_GAIN;
      ST_GAIN:    state_nxt = ST_SCALE;
      ST_SCALE: begin
        if (steps_eq) begin
          state_nxt = ST_EMIT;
        end else if (!primed_r) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_NM;
        end
      end
      ST_NM:      state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (due && !cap) begin
          state_nxt = ST_MOD;
        end else if (due) begin
          state_nxt = ST_SKIP;
        end else begin
          state_nxt = ST_WRAP;
        end
      end
      ST_MOD:     if (div_stat.done) state_nxt = ST_MP;
      ST_MP:      state_nxt = ST_MK;
      ST_MK:      state_nxt = ST_ADD;
      ST_ADD:     state_nxt = ST_ABS;
      ST_ABS:     state_nxt = ST_QUOT;
      ST_QUOT:    if (div_stat.done) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_nxt = eq_r ? ST_IDLE : ST_CHECK;
      end
      ST_SKIP:    if (div_stat.done) state_nxt = ST_SKIPMUL;
      ST_SKIPMUL: state_nxt = ST_SKIPADD;
      ST_SKIPADD: state_nxt = ST_WRAP;
      ST_WRAP:    state_nxt = ST_ADV;
      ST_ADV:     state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_step_r  <= STEP_BITS'(1);
      out_step_r <= STEP_BITS'(1);
      gain_r     <= GAIN_RST;
      offset_r   <= '0;
      zero_r     <= '0;
      bits_r     <= BITS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx)
        CFG_INPUT_STEP:  in_step_r  <= cfg_wdata[STEP_BITS-1:0];
        CFG_OUTPUT_STEP: out_step_r <= cfg_wdata[STEP_BITS-1:0];
        CFG_GAIN:        gain_r     <= cfg_wdata[GAIN_W-1:0];
        CFG_OFFSET:      offset_r   <= cfg_wdata[OFFSET_W-1:0];
        CFG_OUT_ZERO:    zero_r     <= cfg_wdata[ZERO_W-1:0];
        CFG_OUT_BITS:    bits_r     <= cfg_wdata[BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state: sequencer, times, counts and the result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      it_r        <= '0;
      ot_r        <= '0;
      prev_r      <= '0;
      primed_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (!out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_SCALE: begin
          cnt_r <= '0;
          if (!steps_eq && !primed_r) begin
            prev_r   <= v_new;
            primed_r <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (!eq_r) begin
              ot_r  <= ot_plus;
              cnt_r <= cnt_r + CNT_W'(1);
            end
          end
        end
        ST_SKIPADD: ot_r <= ot_r + mul_r[TW-1:0];
        ST_WRAP: begin
          prev_r <= v_r;
          if (it_r > nm_r) begin
            it_r <= it_r - nm_r;
            ot_r <= ot_r - nm_r;
          end
        end
        ST_ADV: it_r <= it_r + TW'(n_eff);
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mul_r <= P_W'(mul_a * $signed({1'b0, mul_b}));
    if (state_r == ST_IDLE && in_valid) sample_r <= in_sample;
    if (state_r == ST_SCALE) begin
      v_r  <= v_new;
      q_r  <= v_new;
      eq_r <= steps_eq;
    end
    if (state_r == ST_NM) nm_r <= mul_r[TW-1:0];
    if (state_r == ST_MOD && div_stat.done) begin
      k_r <= (div_rem == '0) ? n_eff : div_rem;
    end
    if (state_r == ST_MK) acc_r <= $signed(mul_r[ACC_W-1:0]);
    if (state_r == ST_ADD) acc_r <= acc_r + $signed(mul_r[ACC_W-1:0]);
    if (state_r == ST_ABS) neg_r <= acc_r[ACC_W-1];
    if (state_r == ST_QUOT && div_stat.done) q_r <= q_s[VALUE_W-1:0];
    if (state_r == ST_EMIT && out_free) begin
      out_value_r <= q_r;
      out_oor_r   <= (q_r > hi_x) || (q_r < lo_x);
      out_last_r  <= eq_r || !more;
    end
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_out_of_range = out_oor_r;
  assign out_last         = out_last_r;

endmodule

@@ rtl/lirg_props.sv @@
// Port-level checks of the resampler, bound to its top level.
module lirg_props (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [lirg_pkg::VALUE_W-1:0] out_value,
  input logic                               out_last
);

  `include "linear_interp_resampler_with_gain_macros.svh"

  // The block comes out of reset idle with no result pending.
  `LIRG_ASSERT_RST(a_reset_idle, clk, rst_n, !out_valid && !in_stall, "not idle after reset")

  // An accepted beat keeps the block busy in the following cycle.
  `LIRG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "beat accepted but block not busy")

  // With no beat offered, an idle block stays idle.
  `LIRG_ASSERT_NEXT(a_idle_holds, clk, rst_n, !in_valid && !in_stall, !in_stall, "busy without an accepted beat")

  // A stalled result beat holds its payload.
  `LIRG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_value) && $stable(out_last), "stalled result changed")

endmodule

bind linear_interp_resampler_with_gain lirg_props u_lirg_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_value (out_value),
  .out_last  (out_last)
);
